/* rtl/bau_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// bau_pkg
// Shared types, register indexes and helpers for the button auto-repeat
// adjuster.
// ============================================================================
package bau_pkg;

    // Timestamp and configuration widths
    localparam int TIME_W     = 32;
    localparam int MS_CFG_W   = 16;
    localparam int COUNT_W    = 5;
    localparam int INDEX_W    = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Highest number of screens the index may cycle through
    localparam int MAX_SCREENS = 16;
    localparam int COUNT_CAP   = (MAX_SCREENS < 16) ? MAX_SCREENS : 16;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(COUNT_CAP);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COUNT    = 2'd2;

    // Register reset values
    localparam logic [MS_CFG_W-1:0] DELAY_RESET    = 16'd600;
    localparam logic [MS_CFG_W-1:0] INTERVAL_RESET = 16'd100;
    localparam logic [COUNT_W-1:0]  COUNT_RESET    = 5'd4;

    // Step codes
    localparam logic signed [1:0] STEP_NONE  = 2'sb00;
    localparam logic signed [1:0] STEP_PLUS  = 2'sb01;
    localparam logic signed [1:0] STEP_MINUS = 2'sb11;

    // One poll as held in the input register
    typedef struct packed {
        logic              hour;
        logic              minute;
        logic              screen;
        logic              reverse;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

    // Repeat timing settings shared by the hour and minute channels
    typedef struct packed {
        logic [MS_CFG_W-1:0] delay_ms;
        logic [MS_CFG_W-1:0] interval_ms;
    } repeat_cfg_t;

    // Map a fire flag and direction to a signed step
    function automatic logic signed [1:0] step_code(input logic fire, input logic rev);
        logic signed [1:0] code;
        code = STEP_NONE;
        if (fire)
        begin
            code = rev ? STEP_MINUS : STEP_PLUS;
        end
        return code;
    endfunction

    // Clamp the programmed screen count to the usable range
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] c;
        c = count;
        if (c == '0)
        begin
            c = COUNT_W'(1);
        end
        else if (c > COUNT_LIMIT)
        begin
            c = COUNT_LIMIT;
        end
        return c;
    endfunction

endpackage

/* rtl/bau_repeat_ch.sv */
`timescale 1ns / 1ps
// ============================================================================
// bau_repeat_ch
// Press detection and auto-repeat timing for one adjust button.
// ============================================================================
module bau_repeat_ch
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  logic                         button,
    input  logic [bau_pkg::TIME_W-1:0]   now_ms,
    input  bau_pkg::repeat_cfg_t         cfg,
    output logic                         fire
);

    logic                       held_reg;
    logic [bau_pkg::TIME_W-1:0] press_time_reg;
    logic [bau_pkg::TIME_W-1:0] repeat_time_reg;
    logic                       press;
    logic                       repeat_hit;
    logic [bau_pkg::TIME_W-1:0] since_press;
    logic [bau_pkg::TIME_W-1:0] since_repeat;

    // Detect a rising level and a due repeat; a new press cannot repeat at once
    always_comb
    begin
        since_press  = now_ms - press_time_reg;
        since_repeat = now_ms - repeat_time_reg;
        press        = button && !held_reg;
        repeat_hit   = held_reg
                       && (since_press > {{(bau_pkg::TIME_W-bau_pkg::MS_CFG_W){1'b0}},
                                          cfg.delay_ms})
                       && (since_repeat > {{(bau_pkg::TIME_W-bau_pkg::MS_CFG_W){1'b0}},
                                           cfg.interval_ms});
        fire         = press || repeat_hit;
    end

    // Advance the held flag and the press and repeat timestamps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg        <= 1'b0;
            press_time_reg  <= '0;
            repeat_time_reg <= '0;
        end
        else if (step_en)
        begin
            held_reg <= button;
            if (press)
            begin
                press_time_reg <= now_ms;
            end
            if (repeat_hit)
            begin
                repeat_time_reg <= now_ms;
            end
        end
    end

endmodule

/* rtl/bau_screen_sel.sv */
`timescale 1ns / 1ps
// ============================================================================
// bau_screen_sel
// Screen index kept across polls, stepped once per screen button press.
// ============================================================================
module bau_screen_sel
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          button,
    input  logic                          reverse,
    input  logic [bau_pkg::COUNT_W-1:0]   screen_count,
    output logic                          fire,
    output logic [bau_pkg::INDEX_W-1:0]   index_next
);

    logic                         held_reg;
    logic [bau_pkg::INDEX_W-1:0]  index_reg;
    logic [bau_pkg::COUNT_W-1:0]  count;
    logic [bau_pkg::COUNT_W-1:0]  index_wide;
    logic [bau_pkg::COUNT_W-1:0]  index_up;
    logic [bau_pkg::COUNT_W-1:0]  index_down;
    logic [bau_pkg::COUNT_W-1:0]  count_top;
    logic [bau_pkg::INDEX_W-1:0]  stepped;

    // Step forward or back, wrapping within the effective count
    always_comb
    begin
        count      = bau_pkg::eff_count(screen_count);
        index_wide = {1'b0, index_reg};
        index_up   = index_wide + bau_pkg::COUNT_W'(1);
        index_down = index_wide - bau_pkg::COUNT_W'(1);
        count_top  = count - bau_pkg::COUNT_W'(1);
        fire       = button && !held_reg;
        if (reverse)
        begin
            if (index_reg == '0)
            begin
                stepped = count_top[bau_pkg::INDEX_W-1:0];
            end
            else if (index_down >= count)
            begin
                stepped = '0;
            end
            else
            begin
                stepped = index_down[bau_pkg::INDEX_W-1:0];
            end
        end
        else
        begin
            if (index_up >= count)
            begin
                stepped = '0;
            end
            else
            begin
                stepped = index_up[bau_pkg::INDEX_W-1:0];
            end
        end
        index_next = fire ? stepped : index_reg;
    end

    // Hold the index and the button level between polls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            index_reg <= '0;
        end
        else if (step_en)
        begin
            held_reg  <= button;
            index_reg <= index_next;
        end
    end

endmodule

/* rtl/button_autorepeat_adjuster_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// button_autorepeat_adjuster_unit
// Clock setting buttons with auto-repeat and a wrapping screen selector.
// ============================================================================
// Takes one poll per clock cycle while the input side is not stalled and returns one result per poll, in order.
// A poll is captured in an input register, evaluated against the button state
// once the result register can take it and written to the result register.
// The input side stalls only while the result register holds an untaken
// result and the output is stalled. Configuration writes are always ready
// and each is written to its register when accepted.
module button_autorepeat_adjuster_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Poll channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              hour_button,
    input  logic                              minute_button,
    input  logic                              screen_button,
    input  logic                              reverse_button,
    input  logic [bau_pkg::TIME_W-1:0]        now_ms,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [1:0]                 hour_step,
    output logic signed [1:0]                 minute_step,
    output logic                              screen_changed,
    output logic [bau_pkg::INDEX_W-1:0]       screen_now,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bau_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bau_pkg::CFG_DATA_W-1:0]    cfg_data
);

    bau_pkg::repeat_cfg_t              repeat_cfg_reg;
    logic [bau_pkg::COUNT_W-1:0]       screen_count_reg;

    bau_pkg::poll_t                    poll_reg;
    logic                              poll_valid_reg;
    logic                              poll_valid_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_free;
    logic                              step_en;
    logic                              in_take;

    logic                              hour_fire;
    logic                              minute_fire;
    logic                              screen_fire;
    logic [bau_pkg::INDEX_W-1:0]       screen_index_next;

    logic signed [1:0]                 hour_step_reg;
    logic signed [1:0]                 minute_step_reg;
    logic                              screen_changed_reg;
    logic [bau_pkg::INDEX_W-1:0]       screen_now_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_cfg_reg.delay_ms    <= bau_pkg::DELAY_RESET;
            repeat_cfg_reg.interval_ms <= bau_pkg::INTERVAL_RESET;
            screen_count_reg           <= bau_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bau_pkg::CFG_REPEAT_DELAY:
                begin
                    repeat_cfg_reg.delay_ms <= cfg_data;
                end
                bau_pkg::CFG_REPEAT_INTERVAL:
                begin
                    repeat_cfg_reg.interval_ms <= cfg_data;
                end
                bau_pkg::CFG_SCREEN_COUNT:
                begin
                    screen_count_reg <= cfg_data[bau_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    screen_count_reg <= screen_count_reg;
                end
            endcase
        end
    end

    // Flow control: evaluate a held request when the result register can take it
    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        step_en         = poll_valid_reg && out_free;
        in_stall        = poll_valid_reg && !out_free;
        in_take         = in_valid && !in_stall;
        poll_valid_next = in_stall ? poll_valid_reg : in_valid;
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            poll_valid_reg <= poll_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Capture the incoming request
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            poll_reg.hour    <= hour_button;
            poll_reg.minute  <= minute_button;
            poll_reg.screen  <= screen_button;
            poll_reg.reverse <= reverse_button;
            poll_reg.now_ms  <= now_ms;
        end
    end

    // Button channels
    bau_repeat_ch u_hour_ch
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .button  (poll_reg.hour),
        .now_ms  (poll_reg.now_ms),
        .cfg     (repeat_cfg_reg),
        .fire    (hour_fire)
    );

    bau_repeat_ch u_minute_ch
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .button  (poll_reg.minute),
        .now_ms  (poll_reg.now_ms),
        .cfg     (repeat_cfg_reg),
        .fire    (minute_fire)
    );

    bau_screen_sel u_screen_sel
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .button       (poll_reg.screen),
        .reverse      (poll_reg.reverse),
        .screen_count (screen_count_reg),
        .fire         (screen_fire),
        .index_next   (screen_index_next)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            hour_step_reg      <= bau_pkg::step_code(hour_fire, poll_reg.reverse);
            minute_step_reg    <= bau_pkg::step_code(minute_fire, poll_reg.reverse);
            screen_changed_reg <= screen_fire;
            screen_now_reg     <= screen_index_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hour_step      = hour_step_reg;
    assign minute_step    = minute_step_reg;
    assign screen_changed = screen_changed_reg;
    assign screen_now     = screen_now_reg;

`ifndef SYNTHESIS
    // An empty result register never stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty result register");

    // An evaluated request always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("evaluated request lost");

    // A delivered step is never the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hour_step_reg != 2'sb10) && (minute_step_reg != 2'sb10))
        else $error("invalid step code");
`endif

endmodule

/* tb/sv/button_step_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// button_step_checker
// Watches the poll, result and register channels of the button adjuster.
// It predicts the hour, minute and screen steps of every accepted poll,
// queues them in order and compares each accepted result field by field.
// ============================================================================
module button_step_checker
    import bau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Poll channel
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  hour_button,
    input  logic                  minute_button,
    input  logic                  screen_button,
    input  logic                  reverse_button,
    input  logic [TIME_W-1:0]     now_ms,
    // Result channel
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic signed [1:0]     hour_step,
    input  logic signed [1:0]     minute_step,
    input  logic                  screen_changed,
    input  logic [INDEX_W-1:0]    screen_now,
    // Register write channel
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Status for the top
    output int                    mismatch_count,
    output int                    pending_count
);

    typedef struct packed {
        logic signed [1:0]    hour_step;
        logic signed [1:0]    minute_step;
        logic                 screen_changed;
        logic [INDEX_W-1:0]   screen_now;
    } poll_steps_t;

    poll_steps_t pending_steps[$];

    // Register copies
    logic [MS_CFG_W-1:0] delay_ms;
    logic [MS_CFG_W-1:0] interval_ms;
    logic [COUNT_W-1:0]  screen_total;

    // Button state copies
    logic              hour_down;
    logic              minute_down;
    logic              screen_down;
    logic [TIME_W-1:0] hour_pressed_at;
    logic [TIME_W-1:0] minute_pressed_at;
    logic [TIME_W-1:0] hour_repeated_at;
    logic [TIME_W-1:0] minute_repeated_at;
    int                screen_pos;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Work out the steps one poll causes and advance the button state
    task automatic predict_steps(input logic hb, input logic mb, input logic sb,
                                 input logic rev, input logic [TIME_W-1:0] now);
        poll_steps_t       r;
        logic              hour_fire;
        logic              minute_fire;
        logic [TIME_W-1:0] held_for;
        logic [TIME_W-1:0] since_repeat;
        int                usable;
        hour_fire   = 1'b0;
        minute_fire = 1'b0;
        r           = '0;

        // Rising levels fire one step each
        if (hb && !hour_down)
        begin
            hour_fire       = 1'b1;
            hour_down       = 1'b1;
            hour_pressed_at = now;
        end
        if (mb && !minute_down)
        begin
            minute_fire       = 1'b1;
            minute_down       = 1'b1;
            minute_pressed_at = now;
        end
        if (sb && !screen_down)
        begin
            usable = int'(screen_total);
            if (usable < 1)
                usable = 1;
            if (usable > 16)
                usable = 16;
            if (usable > MAX_SCREENS)
                usable = MAX_SCREENS;
            r.screen_changed = 1'b1;
            screen_down      = 1'b1;
            if (rev)
            begin
                if (screen_pos == 0)
                    screen_pos = usable - 1;
                else if (screen_pos - 1 >= usable)
                    screen_pos = 0;
                else
                    screen_pos = screen_pos - 1;
            end
            else
            begin
                if (screen_pos + 1 >= usable)
                    screen_pos = 0;
                else
                    screen_pos = screen_pos + 1;
            end
        end

        // Auto-repeat uses the held flags from before this poll's release
        held_for     = now - hour_pressed_at;
        since_repeat = now - hour_repeated_at;
        if (hour_down && held_for > TIME_W'(delay_ms) && since_repeat > TIME_W'(interval_ms))
        begin
            hour_fire        = 1'b1;
            hour_repeated_at = now;
        end
        held_for     = now - minute_pressed_at;
        since_repeat = now - minute_repeated_at;
        if (minute_down && held_for > TIME_W'(delay_ms) &&
            since_repeat > TIME_W'(interval_ms))
        begin
            minute_fire        = 1'b1;
            minute_repeated_at = now;
        end

        // Drop held flags of released buttons
        if (!hb)
            hour_down = 1'b0;
        if (!mb)
            minute_down = 1'b0;
        if (!sb)
            screen_down = 1'b0;

        r.hour_step   = hour_fire ? (rev ? STEP_MINUS : STEP_PLUS) : STEP_NONE;
        r.minute_step = minute_fire ? (rev ? STEP_MINUS : STEP_PLUS) : STEP_NONE;
        r.screen_now  = INDEX_W'(screen_pos);
        pending_steps.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        poll_steps_t want;
        if (!rst_n)
        begin
            delay_ms           = DELAY_RESET;
            interval_ms        = INTERVAL_RESET;
            screen_total       = COUNT_RESET;
            hour_down          = 1'b0;
            minute_down        = 1'b0;
            screen_down        = 1'b0;
            hour_pressed_at    = '0;
            minute_pressed_at  = '0;
            hour_repeated_at   = '0;
            minute_repeated_at = '0;
            screen_pos         = 0;
            mismatch_count     = 0;
            pending_steps.delete();
            pending_count <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REPEAT_DELAY:    delay_ms     = cfg_data[MS_CFG_W-1:0];
                    CFG_REPEAT_INTERVAL: interval_ms  = cfg_data[MS_CFG_W-1:0];
                    CFG_SCREEN_COUNT:    screen_total = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            // Predict each accepted poll
            if (in_valid && !in_stall)
                predict_steps(hour_button, minute_button, screen_button,
                              reverse_button, now_ms);

            // Compare each accepted result against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (pending_steps.size() == 0)
                    report_mismatch("result with no poll waiting");
                else
                begin
                    want = pending_steps.pop_front();
                    if (hour_step !== want.hour_step)
                        report_mismatch($sformatf("hour_step got %0d want %0d",
                                                  hour_step, want.hour_step));
                    if (minute_step !== want.minute_step)
                        report_mismatch($sformatf("minute_step got %0d want %0d",
                                                  minute_step, want.minute_step));
                    if (screen_changed !== want.screen_changed)
                        report_mismatch($sformatf("screen_changed got %0b want %0b",
                                                  screen_changed, want.screen_changed));
                    if (screen_now !== want.screen_now)
                        report_mismatch($sformatf("screen_now got %0d want %0d",
                                                  screen_now, want.screen_now));
                end
            end

            pending_count <= pending_steps.size();
        end
    end

endmodule

/* tb/sv/tb_button_autorepeat_adjuster_unit.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_button_autorepeat_adjuster_unit
// Drives polls and register writes into the button adjuster under several
// timing and screen settings and idling patterns; a checker beside the
// block predicts and compares every result. This top gives the verdict.
// ============================================================================
module tb_button_autorepeat_adjuster_unit;
    import bau_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 6;
    localparam int PHASE_POLLS = 125;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic                  hour_button    = 1'b0;
    logic                  minute_button  = 1'b0;
    logic                  screen_button  = 1'b0;
    logic                  reverse_button = 1'b0;
    logic [TIME_W-1:0]     now_ms         = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic signed [1:0]     hour_step;
    logic signed [1:0]     minute_step;
    logic                  screen_changed;
    logic [INDEX_W-1:0]    screen_now;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = CFG_REPEAT_DELAY;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    int mismatch_count;
    int pending_count;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int stall_pct = 0;

    // Poll generator state
    logic [TIME_W-1:0] time_cursor = '0;
    logic              hold_hour   = 1'b0;
    logic              hold_minute = 1'b0;
    logic              hold_screen = 1'b0;
    logic              hold_rev    = 1'b0;
    int                cur_delay    = 600;
    int                cur_interval = 100;

    button_autorepeat_adjuster_unit i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .hour_button    (hour_button),
        .minute_button  (minute_button),
        .screen_button  (screen_button),
        .reverse_button (reverse_button),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hour_step      (hour_step),
        .minute_step    (minute_step),
        .screen_changed (screen_changed),
        .screen_now     (screen_now),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    button_step_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .hour_button    (hour_button),
        .minute_button  (minute_button),
        .screen_button  (screen_button),
        .reverse_button (reverse_button),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hour_step      (hour_step),
        .minute_step    (minute_step),
        .screen_changed (screen_changed),
        .screen_now     (screen_now),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #5 clk = ~clk;

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Present one poll and hold it until accepted
    task automatic send_poll(input logic hb, input logic mb, input logic sb,
                             input logic rev, input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        hour_button    <= hb;
        minute_button  <= mb;
        screen_button  <= sb;
        reverse_button <= rev;
        now_ms         <= now;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold off polls until every result is back, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Write one register and drop the request for a cycle afterwards
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Load timing and screen settings; junk rides in the unused upper data bits of the count write
    task automatic apply_settings(input int delay, input int interval, input int count);
        logic [CFG_DATA_W-1:0] word;
        cur_delay    = delay;
        cur_interval = interval;
        write_register(CFG_REPEAT_DELAY, CFG_DATA_W'(delay));
        write_register(CFG_REPEAT_INTERVAL, CFG_DATA_W'(interval));
        word          = CFG_DATA_W'($urandom);
        word[COUNT_W-1:0] = COUNT_W'(count);
        write_register(CFG_SCREEN_COUNT, word);
        @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                sender_idle_pct = 0;
                stall_pct      <= 0;
            end
            1:
            begin
                sender_idle_pct = 49;
                stall_pct      <= 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                stall_pct      <= 49;
            end
            default:
            begin
                sender_idle_pct = 30;
                stall_pct      <= 30;
            end
        endcase
    endtask

    // Mostly held-button sequences with advancing time, some noise polls
    task automatic random_poll();
        int kind;
        int span;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            send_poll(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      TIME_W'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 99) < 12)
                hold_hour = ~hold_hour;
            if ($urandom_range(0, 99) < 12)
                hold_minute = ~hold_minute;
            if ($urandom_range(0, 99) < 30)
                hold_screen = ~hold_screen;
            if ($urandom_range(0, 99) < 20)
                hold_rev = ~hold_rev;
            span = cur_delay / 4 + cur_interval + 20;
            kind = $urandom_range(0, 99);
            if (kind < 5)
                time_cursor = time_cursor;
            else if (kind < 10)
                time_cursor = TIME_W'($urandom);
            else
                time_cursor = time_cursor + TIME_W'($urandom_range(0, span));
            send_poll(hold_hour, hold_minute, hold_screen, hold_rev, time_cursor);
        end
    endtask

    initial
    begin
        int delays[6];
        int intervals[6];
        int counts[6];
        delays    = '{600, 65535, 30, 0, 300, 1};
        intervals = '{100, 65535, 5, 0, 40, 1};
        counts    = '{4, 16, 3, 0, 31, 2};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed polls under the reset settings
        send_poll(0, 0, 0, 0, 32'd0);
        send_poll(1, 0, 0, 0, 32'd10);          // hour press
        send_poll(1, 0, 0, 0, 32'd611);         // first repeat
        send_poll(1, 0, 0, 0, 32'd700);         // interval not yet over
        send_poll(0, 0, 0, 1, 32'd712);         // repeat on the release poll
        send_poll(0, 1, 0, 1, 32'hFFFF_FF00);   // minute press, reverse
        send_poll(0, 1, 0, 0, 32'h0000_0200);   // repeat across the time wrap
        send_poll(1, 1, 0, 0, 32'h0000_0300);   // hour press beside minute repeat
        send_poll(1, 1, 0, 0, 32'h0000_0301);   // both held, no repeat
        send_poll(0, 0, 1, 0, 32'h0000_0400);   // screen forward
        send_poll(0, 0, 1, 0, 32'h0000_2000);   // screen held, no repeat
        send_poll(0, 0, 0, 0, 32'h0000_2001);
        send_poll(0, 0, 1, 1, 32'h0000_2002);   // screen back to 0
        send_poll(0, 0, 0, 1, 32'h0000_2003);
        send_poll(0, 0, 1, 1, 32'h0000_2004);   // backward from 0 wraps to the top
        send_poll(0, 0, 0, 0, 32'h0000_2005);
        send_poll(0, 0, 1, 0, 32'h0000_2006);   // forward off the top wraps to 0
        send_poll(1, 1, 1, 1, 32'hFFFF_FFFF);   // every field high
        send_poll(1, 1, 1, 1, 32'h7FFF_FFFF);
        send_poll(0, 0, 0, 0, 32'h0000_0000);   // every field low
        drain_results();

        // Random phases over the register settings and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            set_idling(ph % 4);
            apply_settings(delays[ph], intervals[ph], counts[ph]);
            for (int n = 0; n < PHASE_POLLS; n++)
            begin
                if (n == PHASE_POLLS / 2)
                    drain_results();
                random_poll();
            end
            drain_results();
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* button_autorepeat_adjuster_unit.f */
rtl/bau_pkg.sv
rtl/bau_repeat_ch.sv
rtl/bau_screen_sel.sv
rtl/button_autorepeat_adjuster_unit.sv
tb/sv/button_step_checker.sv
tb/sv/tb_button_autorepeat_adjuster_unit.sv
